FILE: src/fbrf_pkg.sv
`default_nettype none
package fbrf_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SPAN_W = IDX_W + 1;
  localparam int BYTE_W = 8;
  localparam int FREE_W = 7;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FREE_W-1:0] free_t;

  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic  got;
    logic  done_res;
    free_t free_space;
    logic  data_ready;
  } result_t;

  function automatic idx_t next_idx(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage
`default_nettype wire

FILE: src/fbrf_if.sv
`default_nettype none
interface fbrf_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  fbrf_pkg::byte_t     write_byte;

  modport source (output valid, output action, output write_byte, input ready);
  modport sink   (input valid, input action, input write_byte, output ready);
endinterface

interface fbrf_out_if;
  logic                valid;
  logic                ready;
  fbrf_pkg::byte_t     read_byte;
  logic                done_res;
  fbrf_pkg::free_t     free_space;
  logic                data_ready;

  modport source (output valid, output read_byte, output done_res, output free_space,
                  output data_ready, input ready);
  modport sink   (input valid, input read_byte, input done_res, input free_space,
                  input data_ready, output ready);
endinterface
`default_nettype wire

FILE: src/fbrf_ram.sv
`default_nettype none
module fbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/fbrf_ctrl.sv
`default_nettype none
module fbrf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic              action,
  input  wire fbrf_pkg::byte_t   write_byte,
  output fbrf_pkg::ram_req_t     ram_req,
  output fbrf_pkg::result_t      result
);

  fbrf_pkg::idx_t            write_index, write_index_next;
  fbrf_pkg::idx_t            read_index, read_index_next;
  logic                      full, full_next;
  logic                      do_put, do_get;
  logic [fbrf_pkg::SPAN_W-1:0] span;

  // occupied cells run from read_index up to write_index; equal pointers are full or empty
  always_comb begin
    do_put = take && (action == fbrf_pkg::ACT_PUT) && !full;
    do_get = take && (action == fbrf_pkg::ACT_GET) && (full || (write_index != read_index));

    full_next        = full;
    write_index_next = write_index;
    read_index_next  = read_index;
    if (do_put) begin
      write_index_next = fbrf_pkg::next_idx(write_index);
      full_next        = (fbrf_pkg::next_idx(write_index) == read_index);
    end
    if (do_get) begin
      read_index_next = fbrf_pkg::next_idx(read_index);
      full_next       = 1'b0;
    end

    // free cells after the step; equal pointers over an occupied cell mean full
    if (write_index_next < read_index_next) begin
      span = {1'b0, read_index_next} - {1'b0, write_index_next};
    end else if (write_index_next == read_index_next && full_next) begin
      span = '0;
    end else begin
      span = fbrf_pkg::SPAN_W'(fbrf_pkg::DEPTH)
             - {1'b0, write_index_next - read_index_next};
    end

    ram_req.wr_en   = do_put;
    ram_req.wr_addr = write_index;
    ram_req.wr_data = write_byte;
    ram_req.rd_en   = do_get;
    ram_req.rd_addr = read_index;

    result.got        = do_get;
    result.done_res   = do_put || do_get;
    result.free_space = fbrf_pkg::FREE_W'(span);
    result.data_ready = full_next || (write_index_next != read_index_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      full        <= 1'b0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      full        <= full_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/flagged_byte_ring_fifo.sv
// Byte ring FIFO of 64 cells; a cell's occupied flag follows from the two
// pointers and a full bit.
// req channel: one item per handshake, action selects put (store write_byte)
// or get (take the byte under the read pointer). A put into an occupied cell
// drops the byte; a get from a free cell returns 0. Either way done_res is 0.
// rsp channel: one item for every request item, in order, carrying read_byte,
// done_res, free_space (free cells after the step) and data_ready.
// Latency: the response is valid in the cycle after the request is accepted.
// Throughput: one item per cycle while rsp is not stalled; the pointer and
// flag update is combinational; the byte store has one write and one read port.
// A stalled response holds in the output register; req.ready stays low until
// the response is taken, then a new item may enter in that same cycle.
// Reset empties the ring and clears both pointers at once; cell contents are
// not cleared and are only read after a put has filled them.
`default_nettype none
module flagged_byte_ring_fifo (
  input wire logic  clk,
  input wire logic  rst,
  fbrf_in_if.sink   req,
  fbrf_out_if.source rsp
);

  logic               take;
  fbrf_pkg::ram_req_t ram_req;
  fbrf_pkg::result_t  result_next, result;
  fbrf_pkg::byte_t    ram_q;
  logic               rsp_valid;

  assign req.ready = !rsp_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  fbrf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .action     (req.action),
    .write_byte (req.write_byte),
    .ram_req    (ram_req),
    .result     (result_next)
  );

  fbrf_ram #(
    .WIDTH (fbrf_pkg::BYTE_W),
    .DEPTH (fbrf_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_byte  = result.got ? ram_q : '0;
  assign rsp.done_res   = result.done_res;
  assign rsp.free_space = result.free_space;
  assign rsp.data_ready = result.data_ready;

endmodule
`default_nettype wire
